// ===== design/odq_pkg.sv =====
package odq_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Operation codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REMOVE     = 3'd4,
        OP_CONTAINS   = 3'd5
    } t_opcode;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What a cell does with its stored value at the update edge
    typedef enum logic [1:0] {
        ACT_KEEP       = 2'd0,
        ACT_TAKE_LEFT  = 2'd1,
        ACT_TAKE_RIGHT = 2'd2,
        ACT_LOAD       = 2'd3
    } t_cell_act;

    // Control that the sequencer hands to each cell
    typedef struct packed {
        t_cell_act act;
        logic      cmp_en;
    } t_cell_ctrl;

endpackage

// ===== design/odq_cell.sv =====
module odq_cell (
    input  logic                       i_clk,
    input  odq_pkg::t_cell_ctrl        i_ctrl,
    input  logic [odq_pkg::DATA_W-1:0] i_cmp_value,
    input  logic [odq_pkg::DATA_W-1:0] i_load_value,
    input  logic [odq_pkg::DATA_W-1:0] i_left_value,
    input  logic [odq_pkg::DATA_W-1:0] i_right_value,
    output logic [odq_pkg::DATA_W-1:0] o_value,
    output logic                       o_match
);
    import odq_pkg::*;

    logic [DATA_W-1:0] r_value;
    logic              r_match;

    // Compare against the broadcast value, then hold, shift or load
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_match <= (r_value == i_cmp_value);
        end
        unique case (i_ctrl.act)
            ACT_KEEP:       r_value <= r_value;
            ACT_TAKE_LEFT:  r_value <= i_left_value;
            ACT_TAKE_RIGHT: r_value <= i_right_value;
            ACT_LOAD:       r_value <= i_load_value;
            default:        r_value <= r_value;
        endcase
    end

    assign o_value = r_value;
    assign o_match = r_match;

endmodule

// ===== design/ordered_deque_with_value_removal.sv =====
// Channel   | Ports                                             | Handshake
// ----------+---------------------------------------------------+---------------------------
// command   | i_opcode, i_item_value                            | start high, busy low
// result    | o_popped_value, o_hit, o_count_after, o_status    | o_valid, one-cycle strobe
//
// At acceptance of an item every cell compares its value with i_item_value
// and registers the match; in the next cycle the cells shift or load as the
// operation needs and the result is registered. busy is high for that update
// cycle, so no new item is accepted until the previous one has finished it.
// o_valid pulses for one cycle, in the cycle after the item's busy cycle.
// Reset clears the entry count and the control; cell contents stay as they are.
module ordered_deque_with_value_removal (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [2:0]                        i_opcode,
    input  logic signed [odq_pkg::DATA_W-1:0] i_item_value,
    output logic                              o_valid,
    output logic signed [odq_pkg::DATA_W-1:0] o_popped_value,
    output logic                              o_hit,
    output logic [odq_pkg::CNT_W-1:0]         o_count_after,
    output logic [1:0]                        o_status
);
    import odq_pkg::*;

    logic              accept;
    logic              r_busy;
    t_opcode           r_op;
    logic [DATA_W-1:0] r_item;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_valid;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] n_popped;
    logic              r_hit;
    logic              n_hit;
    t_status           r_status;
    t_status           n_status;

    logic [DATA_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0] cell_match;
    t_cell_ctrl          cell_ctrl [CAPACITY];

    logic [CAPACITY-1:0] live_match;
    logic [CAPACITY-1:0] mid_match;
    logic [CAPACITY-1:0] mid_from;
    logic                head_hit;
    logic                tail_hit;
    logic                full;
    logic                empty;
    logic [DATA_W-1:0]   tail_value;

    assign accept = start & ~r_busy;
    assign busy   = r_busy;

    // Row of cells, front at position zero
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [DATA_W-1:0] left_value;
        logic [DATA_W-1:0] right_value;
        if (k == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_inner_l
            assign left_value = cell_value[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_inner_r
            assign right_value = cell_value[k+1];
        end
        odq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (cell_ctrl[k]),
            .i_cmp_value  (i_item_value),
            .i_load_value (r_item),
            .i_left_value (left_value),
            .i_right_value(right_value),
            .o_value      (cell_value[k]),
            .o_match      (cell_match[k])
        );
    end

    // Qualify matches and find the entry that a remove takes
    always_comb begin
        full       = (r_count == CNT_W'(CAPACITY));
        empty      = (r_count == '0);
        tail_hit   = 1'b0;
        tail_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            live_match[k] = cell_match[k] & (CNT_W'(k) < r_count);
            mid_match[k]  = live_match[k] & (k != 0) & (CNT_W'(k + 1) < r_count);
            if (CNT_W'(k + 1) == r_count) begin
                tail_hit   = live_match[k];
                tail_value = cell_value[k];
            end
        end
        head_hit    = live_match[0];
        mid_from[0] = mid_match[0];
        for (int k = 1; k < CAPACITY; k++) begin
            mid_from[k] = mid_from[k-1] | mid_match[k];
        end
    end

    // Drive the cells and build the result
    always_comb begin
        n_count  = r_count;
        n_popped = '0;
        n_hit    = 1'b0;
        n_status = ST_OK;
        for (int k = 0; k < CAPACITY; k++) begin
            cell_ctrl[k].cmp_en = accept;
            cell_ctrl[k].act    = ACT_KEEP;
        end
        if (r_busy) begin
            unique case (r_op)
                OP_PUSH_FRONT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        for (int k = 0; k < CAPACITY; k++) begin
                            cell_ctrl[k].act = (k == 0) ? ACT_LOAD : ACT_TAKE_LEFT;
                        end
                    end
                end
                OP_PUSH_BACK: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        for (int k = 0; k < CAPACITY; k++) begin
                            if (CNT_W'(k) == r_count) begin
                                cell_ctrl[k].act = ACT_LOAD;
                            end
                        end
                    end
                end
                OP_POP_FRONT: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped = cell_value[0];
                        n_count  = r_count - CNT_W'(1);
                        for (int k = 0; k < CAPACITY; k++) begin
                            cell_ctrl[k].act = ACT_TAKE_RIGHT;
                        end
                    end
                end
                OP_POP_BACK: begin
                    if (empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped = tail_value;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    priority if (head_hit) begin
                        n_hit   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                        for (int k = 0; k < CAPACITY; k++) begin
                            cell_ctrl[k].act = ACT_TAKE_RIGHT;
                        end
                    end else if (tail_hit) begin
                        n_hit   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end else if (mid_from[CAPACITY-1]) begin
                        n_hit   = 1'b1;
                        n_count = r_count - CNT_W'(1);
                        for (int k = 0; k < CAPACITY; k++) begin
                            if (mid_from[k]) begin
                                cell_ctrl[k].act = ACT_TAKE_RIGHT;
                            end
                        end
                    end else begin
                        n_hit = 1'b0;
                    end
                end
                OP_CONTAINS: begin
                    n_hit = |live_match;
                end
                default: begin
                    n_hit = 1'b0;
                end
            endcase
        end
    end

    // Control: busy flag, result strobe and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= accept;
            r_valid <= r_busy;
            r_count <= n_count;
        end
    end

    // Latch the item and register the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_opcode'(i_opcode);
            r_item <= i_item_value;
        end
        if (r_busy) begin
            r_popped <= n_popped;
            r_hit    <= n_hit;
            r_status <= n_status;
        end
    end

    assign o_valid        = r_valid;
    assign o_popped_value = r_popped;
    assign o_hit          = r_hit;
    assign o_count_after  = r_count;
    assign o_status       = r_status;

endmodule
